/* design/wfg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package wfg_pkg;

    localparam int NODES = 32;
    localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;

    typedef logic [NODES-1:0] t_row;
    typedef logic [IDX_W-1:0] t_idx;

    localparam logic [2:0] OP_ADD_EDGE = 3'd0;
    localparam logic [2:0] OP_REM_EDGE = 3'd1;
    localparam logic [2:0] OP_CLR_OUT  = 3'd2;
    localparam logic [2:0] OP_REM_NODE = 3'd3;
    localparam logic [2:0] OP_CLR_ALL  = 3'd4;
    localparam logic [2:0] OP_QUERY    = 3'd5;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LOAD  = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

endpackage

`default_nettype wire

/* design/wait_for_graph_deadlock_detector_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Wait-for graph deadlock detector. Each accepted word edits the wait graph
// (add or remove an edge, clear a node's outgoing edges, remove a node, clear
// all, or just query; opcodes 6 and 7 act as a query) and returns one word
// telling whether any cycle exists and whether the waiter node lies on one.
// The edit lands at the accept edge. A load state then copies the graph into
// the reachability matrix. A transitive-closure sweep takes one pivot node per
// cycle, and a done state forms the result once the output is free, so a
// stalled output delays it. The input is stalled until the result is
// registered and opens again in the same cycle that the result word becomes
// valid, so a new word is taken only after the last one's result is out.
// The graph resets to empty.
module wait_for_graph_deadlock_detector_top
    import wfg_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [2:0] i_opcode,
    input  wire logic [4:0] i_waiter,
    input  wire logic [4:0] i_holder,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_any_deadlock,
    output logic            o_waiter_in_cycle
);

    logic [1:0] r_state, n_state;
    t_idx       r_pivot;
    t_idx       r_widx;
    logic       r_w_ok;
    t_row       r_wait  [NODES];
    t_row       r_reach [NODES];
    logic       r_out_valid;
    logic       r_any;
    logic       r_self;

    logic       accept;
    logic       w_ok, h_ok;
    t_idx       w_idx, h_idx;
    t_row       w_bit, h_bit;
    t_row       pivot_row;
    logic       out_free;
    logic       diag_any;

    assign accept   = i_in_valid && (r_state == ST_IDLE);
    assign w_ok     = int'(i_waiter) < NODES;
    assign h_ok     = int'(i_holder) < NODES;
    assign w_idx    = IDX_W'(i_waiter);
    assign h_idx    = IDX_W'(i_holder);
    assign w_bit    = t_row'(1) << w_idx;
    assign h_bit    = t_row'(1) << h_idx;
    assign pivot_row = r_reach[r_pivot];
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        diag_any = 1'b0;
        for (int i = 0; i < NODES; i++) begin
            diag_any = diag_any | r_reach[i][i];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: n_state = ST_SWEEP;
            ST_SWEEP: begin
                if (int'(r_pivot) == NODES - 1) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pivot     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SWEEP) begin
                r_pivot <= r_pivot + t_idx'(1);
            end else begin
                r_pivot <= '0;
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // graph edit, applied at the accept edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NODES; i++) begin
                r_wait[i] <= '0;
            end
        end else if (accept) begin
            for (int i = 0; i < NODES; i++) begin
                case (i_opcode)
                    OP_ADD_EDGE: begin
                        if (w_ok && h_ok && int'(w_idx) == i) begin
                            r_wait[i] <= r_wait[i] | h_bit;
                        end
                    end
                    OP_REM_EDGE: begin
                        if (w_ok && h_ok && int'(w_idx) == i) begin
                            r_wait[i] <= r_wait[i] & ~h_bit;
                        end
                    end
                    OP_CLR_OUT: begin
                        if (w_ok && int'(w_idx) == i) begin
                            r_wait[i] <= '0;
                        end
                    end
                    OP_REM_NODE: begin
                        if (w_ok) begin
                            if (int'(w_idx) == i) begin
                                r_wait[i] <= '0;
                            end else begin
                                r_wait[i] <= r_wait[i] & ~w_bit;
                            end
                        end
                    end
                    OP_CLR_ALL: r_wait[i] <= '0;
                    default: ;
                endcase
            end
        end
    end

    // closure: each row ors in the pivot row when it reaches the pivot
    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOAD) begin
            for (int i = 0; i < NODES; i++) begin
                r_reach[i] <= r_wait[i];
            end
        end else if (r_state == ST_SWEEP) begin
            for (int i = 0; i < NODES; i++) begin
                if (r_reach[i][r_pivot]) begin
                    r_reach[i] <= r_reach[i] | pivot_row;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_widx <= w_idx;
            r_w_ok <= w_ok;
        end
        if (r_state == ST_DONE && out_free) begin
            r_any  <= diag_any;
            r_self <= r_w_ok && r_reach[r_widx][r_widx];
        end
    end

    assign o_in_stall        = (r_state != ST_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_any_deadlock    = r_any;
    assign o_waiter_in_cycle = r_self;

endmodule

`default_nettype wire
